@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each use sits on a line of its own.
// Both sample on clk and are held off while rst_n is low, so the using scope
// must have those two signals.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define BRMW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off while reset is asserted
`define BRMW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/brmw_pkg.sv @@
package brmw_pkg;

    localparam int MAG_W          = 16;
    localparam int MAX_BLOCK_DEF  = 1024;
    localparam int RING_DEPTH_DEF = 5;

    localparam logic [MAG_W-1:0] FLOOR_RESET = 16'd60000;
    localparam logic [MAG_W-1:0] WEIGHT_MAX  = 16'hFFFF;

    // Operand set loaded into the shared divider
    typedef enum logic [1:0] {
        DIV_SUM,
        DIV_WEIGHT
    } div_sel_t;

    typedef struct packed {
        logic     take;
        logic     accum;
        logic     div_start;
        div_sel_t div_sel;
        logic     sqrt_start;
        logic     ring_update;
        logic     x_from_rms;
        logic     x_from_mean;
        logic     load_out;
    } brmw_cmd_t;

    typedef struct packed {
        logic last;
        logic mode;
        logic div_done;
        logic sqrt_done;
        logic need_div;
    } brmw_status_t;

endpackage

@@ rtl/core/brmw_in_if.sv @@
interface brmw_in_if import brmw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] sample_magnitude;
    logic             last_sample;

    modport source (output valid, output sample_magnitude, output last_sample, input ready);
    modport sink   (input valid, input sample_magnitude, input last_sample, output ready);
endinterface

@@ rtl/core/brmw_out_if.sv @@
interface brmw_out_if import brmw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] weight_out;
    logic [MAG_W-1:0] rms_out;
    logic             degenerate;
    logic             spread_factor;

    modport source (output valid, output weight_out, output rms_out, output degenerate,
                    output spread_factor, input ready);
    modport sink   (input valid, input weight_out, input rms_out, input degenerate,
                    input spread_factor, output ready);
endinterface

@@ rtl/core/brmw_cfg_if.sv @@
interface brmw_cfg_if ();
    logic valid;
    logic ready;
    logic weight_mode;

    modport source (output valid, output weight_mode, input ready);
    modport sink   (input valid, input weight_mode, output ready);
endinterface

@@ rtl/core/block_rms_min_max_weight.sv @@
// Block RMS weighting. Each sample item is first accepted, then its square is added
// into the block sum. The item flagged last also closes the block: the shared
// one-bit-per-cycle divider forms sum/count (2*16 + clog2(MAX_BLOCK+1) steps, 43 at
// the default), a 16-step square-root unit forms the RMS, the ring, peak and floor are
// updated, the ring mean (weight_mode 0) comes from a reciprocal multiply, and the
// divider runs again for the weight quotient when the RMS or ring mean lies strictly
// between floor and peak. A closing item also waits for the output register to be
// free. The result waits in an output register; sample accumulation for the next
// block proceeds while it waits. The configuration channel is always ready; the user
// must write it only while no block is being closed, which the block itself does
// not enforce.
`include "assert_macros.svh"

module block_rms_min_max_weight import brmw_pkg::*; #(
    parameter int MAX_BLOCK  = MAX_BLOCK_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    brmw_in_if.sink  samples,
    brmw_out_if.source results,
    brmw_cfg_if.sink cfg
);

    brmw_cmd_t    cmd;
    brmw_status_t status;

    brmw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd),
        .status    (status)
    );

    brmw_dp #(
        .MAX_BLOCK  (MAX_BLOCK),
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .sample_magnitude (samples.sample_magnitude),
        .last_sample      (samples.last_sample),
        .cfg_we           (cfg.valid),
        .cfg_mode         (cfg.weight_mode),
        .weight_out       (results.weight_out),
        .rms_out          (results.rms_out),
        .degenerate       (results.degenerate)
    );

    assign cfg.ready             = 1'b1;
    assign results.spread_factor = 1'b1;

    `BRMW_ASSERT_NEXT(a_take_then_accum, samples.valid && samples.ready, cmd.accum)
    `BRMW_ASSERT_IMPL(a_degen_zero, results.valid && results.degenerate, results.weight_out == '0)
    `BRMW_ASSERT_NEXT(a_load_then_ready, cmd.load_out, samples.ready && results.valid)

endmodule

@@ rtl/core/brmw_div.sv @@
module brmw_div #(
    parameter int DVD_W = 43,
    parameter int DVS_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    shifted;
    logic [DVS_W:0]    diff;

    // Restoring division, one quotient bit per cycle, MSB first
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DVD_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_W'(DVD_W);
        end
        else if (step_reg != '0)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/brmw_sqrt.sv @@
module brmw_sqrt #(
    parameter int RT_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2*RT_W-1:0] radicand,
    output logic              done,
    output logic [RT_W-1:0]   root
);

    localparam int STEP_W = $clog2(RT_W + 1);

    logic [2*RT_W-1:0] rad_reg, rad_next;
    logic [RT_W-1:0]   root_reg, root_next;
    logic [RT_W:0]     rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [RT_W+2:0]   shifted;
    logic [RT_W+2:0]   trial;
    logic [RT_W+2:0]   diff;

    // Digit-by-digit root: bring down two radicand bits, try {root, 01}
    always_comb
    begin
        shifted   = {rem_reg, rad_reg[2*RT_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = shifted - trial;
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            root_next = '0;
            rem_next  = '0;
            step_next = STEP_W'(RT_W);
        end
        else if (step_reg != '0)
        begin
            rad_next = {rad_reg[2*RT_W-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = diff[RT_W:0];
                root_next = {root_reg[RT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[RT_W:0];
                root_next = {root_reg[RT_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/core/brmw_dp.sv @@
module brmw_dp import brmw_pkg::*; #(
    parameter int MAX_BLOCK  = MAX_BLOCK_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  brmw_cmd_t        cmd,
    output brmw_status_t     status,
    input  logic [MAG_W-1:0] sample_magnitude,
    input  logic             last_sample,
    input  logic             cfg_we,
    input  logic             cfg_mode,
    output logic [MAG_W-1:0] weight_out,
    output logic [MAG_W-1:0] rms_out,
    output logic             degenerate
);

    localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W  = 2 * MAG_W + CNT_W;
    localparam int DVS_W  = (CNT_W > MAG_W) ? CNT_W : MAG_W;
    localparam int RIDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int TOT_W  = MAG_W + $clog2(RING_DEPTH + 1);
    // Ring mean by reciprocal multiply, exact for every ring total
    localparam int MEAN_SH  = TOT_W + $clog2(RING_DEPTH);
    localparam int RCP_W    = MEAN_SH + 1;
    localparam int MEAN_RCP = ((1 << MEAN_SH) + RING_DEPTH - 1) / RING_DEPTH;

    logic [2*MAG_W-1:0] sq_reg;
    logic               last_reg;
    logic               mode_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MAG_W-1:0]   ring_reg [RING_DEPTH];
    logic [MAG_W-1:0]   ring_next [RING_DEPTH];
    logic [RIDX_W-1:0]  pos_reg, pos_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [MAG_W-1:0]   peak_reg, peak_next;
    logic [MAG_W-1:0]   floor_reg, floor_next;
    logic [MAG_W-1:0]   x_reg;
    logic [MAG_W-1:0]   weight_reg, weight_next;
    logic [MAG_W-1:0]   rms_reg;
    logic               degen_reg;

    logic [SUM_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic               div_done;
    logic [SUM_W-1:0]   div_quo;
    logic               sqrt_done;
    logic [MAG_W-1:0]   root;
    logic               degen_now;
    logic [TOT_W+RCP_W-1:0] mean_prod;
    logic [MAG_W-1:0]   mean_val;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_SUM:
            begin
                div_dvd = sum_reg;
                div_dvs = DVS_W'(cnt_reg);
            end
            DIV_WEIGHT:
            begin
                div_dvd = SUM_W'({x_reg - floor_reg, {MAG_W{1'b0}}});
                div_dvs = DVS_W'(peak_reg - floor_reg);
            end
            default:
            begin
                div_dvd = '0;
                div_dvs = '0;
            end
        endcase
    end

    brmw_div #(
        .DVD_W (SUM_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Mean square never exceeds 16 bits squared
    brmw_sqrt #(
        .RT_W (MAG_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (div_quo[2*MAG_W-1:0]),
        .done     (sqrt_done),
        .root     (root)
    );

    assign mean_prod = {{RCP_W{1'b0}}, total_reg} * {{TOT_W{1'b0}}, RCP_W'(MEAN_RCP)};
    assign mean_val  = mean_prod[MEAN_SH +: MAG_W];

    always_comb
    begin
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        ring_next  = ring_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        peak_next  = peak_reg;
        floor_next = floor_reg;
        // Drop samples past the block limit
        if (cmd.accum && (cnt_reg != CNT_W'(MAX_BLOCK)))
        begin
            sum_next = sum_reg + SUM_W'(sq_reg);
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.ring_update)
        begin
            sum_next           = '0;
            cnt_next           = '0;
            ring_next[pos_reg] = root;
            total_next         = total_reg - TOT_W'(ring_reg[pos_reg]) + TOT_W'(root);
            pos_next           = (pos_reg == RIDX_W'(RING_DEPTH - 1)) ? '0
                                                                     : pos_reg + RIDX_W'(1);
            if (root > peak_reg)
            begin
                peak_next = root;
            end
            if (root < floor_reg)
            begin
                floor_next = root;
            end
        end
    end

    assign degen_now = (peak_reg <= floor_reg);

    always_comb
    begin
        if (degen_now || (x_reg <= floor_reg))
        begin
            weight_next = '0;
        end
        else if (x_reg >= peak_reg)
        begin
            weight_next = WEIGHT_MAX;
        end
        else
        begin
            weight_next = div_quo[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            pos_reg   <= '0;
            total_reg <= '0;
            peak_reg  <= '0;
            floor_reg <= FLOOR_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_mode;
            end
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            ring_reg  <= ring_next;
            pos_reg   <= pos_next;
            total_reg <= total_next;
            peak_reg  <= peak_next;
            floor_reg <= floor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            sq_reg   <= sample_magnitude * sample_magnitude;
            last_reg <= last_sample;
        end
        if (cmd.x_from_rms)
        begin
            x_reg <= root;
        end
        else if (cmd.x_from_mean)
        begin
            x_reg <= mean_val;
        end
        if (cmd.load_out)
        begin
            weight_reg <= weight_next;
            rms_reg    <= root;
            degen_reg  <= degen_now;
        end
    end

    assign status.last      = last_reg;
    assign status.mode      = mode_reg;
    assign status.div_done  = div_done;
    assign status.sqrt_done = sqrt_done;
    assign status.need_div  = !degen_now && (x_reg > floor_reg) && (x_reg < peak_reg);

    assign weight_out = weight_reg;
    assign rms_out    = rms_reg;
    assign degenerate = degen_reg;

endmodule

@@ rtl/core/brmw_ctrl.sv @@
module brmw_ctrl import brmw_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output brmw_cmd_t    cmd,
    input  brmw_status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_SUM_GO,
        ST_SUM_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_RING,
        ST_MEAN,
        ST_CHECK,
        ST_WDIV_GO,
        ST_WDIV_WAIT,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.div_sel    = DIV_SUM;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = status.last ? ST_SUM_GO : ST_IDLE;
            end
            ST_SUM_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SUM;
                state_next    = ST_SUM_WAIT;
            end
            ST_SUM_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_SQRT_GO;
                end
            end
            ST_SQRT_GO:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (status.sqrt_done)
                begin
                    state_next = ST_RING;
                end
            end
            ST_RING:
            begin
                cmd.ring_update = 1'b1;
                if (status.mode)
                begin
                    cmd.x_from_rms = 1'b1;
                    state_next     = ST_CHECK;
                end
                else
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                // Ring total is settled here; take its mean
                cmd.x_from_mean = 1'b1;
                state_next      = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = status.need_div ? ST_WDIV_GO : ST_OUT;
            end
            ST_WDIV_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_WEIGHT;
                state_next    = ST_WDIV_WAIT;
            end
            ST_WDIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Hold until the output register is free or being drained
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ tb/block_rms_min_max_weight_tb.sv @@
`timescale 1ns / 100ps

module block_rms_min_max_weight_tb;
    import brmw_pkg::*;

    localparam int RESET_CYCLES    = 7;
    localparam int STALL_LIMIT     = 20000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int PHASE_ITEMS     = 40;
    localparam int RANDOM_ITEMS    = 1200;
    localparam int MAX_REPORTS     = 10;

    localparam logic MODE_RING_MEAN = 1'b0;
    localparam logic MODE_BLOCK_RMS = 1'b1;

    typedef struct packed {
        logic [MAG_W-1:0] weight;
        logic [MAG_W-1:0] rms;
        logic             degen;
        logic             spread;
    } rms_result_t;

    typedef enum logic [1:0] {
        CFG_KEEP,
        CFG_RING_MEAN,
        CFG_BLOCK_RMS
    } cfg_step_t;

    typedef enum int {
        MAG_ANY,
        MAG_LOW,
        MAG_HIGH,
        MAG_FLAT
    } mag_style_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             last;
        cfg_step_t        cfg;
        logic             typed;
        rms_result_t      want;
    } stim_row_t;

    localparam int DIR_ROWS = 18;

    // Known results only where they follow directly from the reset state and the rows before
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        '{16'd0,     1'b1, CFG_RING_MEAN, 1'b1, '{16'd0,     16'd0,     1'b1, 1'b1}},
        '{16'd65535, 1'b1, CFG_KEEP,      1'b0, '0},
        '{16'd65535, 1'b1, CFG_BLOCK_RMS, 1'b1, '{16'd65535, 16'd65535, 1'b0, 1'b1}},
        '{16'd0,     1'b1, CFG_KEEP,      1'b1, '{16'd0,     16'd0,     1'b0, 1'b1}},
        '{16'd30000, 1'b0, CFG_KEEP,      1'b0, '0},
        '{16'd40000, 1'b1, CFG_KEEP,      1'b0, '0},
        '{16'hAAAA,  1'b0, CFG_KEEP,      1'b0, '0},
        '{16'h5555,  1'b1, CFG_KEEP,      1'b0, '0},
        '{16'd12345, 1'b1, CFG_RING_MEAN, 1'b0, '0},
        '{16'hFFFF,  1'b0, CFG_KEEP,      1'b0, '0},
        '{16'd0,     1'b0, CFG_KEEP,      1'b0, '0},
        '{16'h1234,  1'b1, CFG_KEEP,      1'b0, '0},
        '{16'd100,   1'b1, CFG_KEEP,      1'b0, '0},
        '{16'd200,   1'b1, CFG_KEEP,      1'b0, '0},
        '{16'd7,     1'b1, CFG_KEEP,      1'b0, '0},
        '{16'h8000,  1'b0, CFG_KEEP,      1'b0, '0},
        '{16'h7FFF,  1'b1, CFG_KEEP,      1'b0, '0},
        '{16'd1,     1'b1, CFG_KEEP,      1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    brmw_in_if  in_ch ();
    brmw_out_if out_ch ();
    brmw_cfg_if cfg_ch ();

    block_rms_min_max_weight dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (in_ch),
        .results (out_ch),
        .cfg     (cfg_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state
    logic [63:0]      blk_energy;
    int unsigned      blk_len;
    logic [MAG_W-1:0] rms_hist [RING_DEPTH_DEF];
    int unsigned      hist_slot;
    int unsigned      hist_sum;
    logic [MAG_W-1:0] rms_hi;
    logic [MAG_W-1:0] rms_lo;
    logic             mode_now;

    rms_result_t expected_rms_q [$];

    int unsigned items_in;
    int unsigned results_out;
    int unsigned errors;
    int unsigned idle_cycles;
    int unsigned random_items;
    int unsigned overlong_blocks;
    int          burst_left;
    bit          hold_off_req;

    function automatic logic [MAG_W-1:0] isqrt32(logic [31:0] v);
        logic [MAG_W-1:0] root;
        logic [31:0]      trial;
        root = '0;
        for (int b = MAG_W - 1; b >= 0; b--)
        begin
            trial = {16'd0, root | (16'd1 << b)};
            if (trial * trial <= v)
                root = trial[MAG_W-1:0];
        end
        return root;
    endfunction

    // Close the open block: RMS, ring, peak/floor, then the weight
    function automatic rms_result_t close_block();
        rms_result_t      r;
        logic [31:0]      mean_sq;
        logic [MAG_W-1:0] rms;
        logic [MAG_W-1:0] x;
        logic [31:0]      num;
        mean_sq = 32'(blk_energy / blk_len);
        rms = isqrt32(mean_sq);
        blk_energy = '0;
        blk_len = 0;
        hist_sum = hist_sum - rms_hist[hist_slot] + rms;
        rms_hist[hist_slot] = rms;
        hist_slot = (hist_slot == RING_DEPTH_DEF - 1) ? 0 : hist_slot + 1;
        if (rms > rms_hi)
            rms_hi = rms;
        if (rms < rms_lo)
            rms_lo = rms;
        x = (mode_now == MODE_BLOCK_RMS) ? rms : MAG_W'(hist_sum / RING_DEPTH_DEF);
        r.rms = rms;
        r.spread = 1'b1;
        r.degen = 1'b0;
        r.weight = '0;
        if (rms_hi <= rms_lo)
            r.degen = 1'b1;
        else if (x > rms_lo)
        begin
            if (x >= rms_hi)
                r.weight = WEIGHT_MAX;
            else
            begin
                num = {x - rms_lo, 16'd0};
                r.weight = MAG_W'(num / (rms_hi - rms_lo));
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        rms_result_t want;
        rms_result_t got;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.weight_out, out_ch.rms_out, out_ch.degenerate,
                        out_ch.spread_factor};
                results_out++;
                if (expected_rms_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected result %0d: weight %0d rms %0d", results_out,
                                 got.weight, got.rms);
                end
                else
                begin
                    want = expected_rms_q.pop_front();
                    if (got.weight !== want.weight || got.rms !== want.rms ||
                        got.degen !== want.degen || got.spread !== want.spread)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"mismatch on result %0d (expected/actual): weight %0d/%0d",
                                      " rms %0d/%0d degenerate %0b/%0b spread %0b/%0b"},
                                     results_out, want.weight, got.weight, want.rms, got.rms,
                                     want.degen, got.degen, want.spread, got.spread);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                // drop samples past the block limit
                if (blk_len < MAX_BLOCK_DEF)
                begin
                    blk_energy += 64'(in_ch.sample_magnitude) * 64'(in_ch.sample_magnitude);
                    blk_len++;
                end
                if (in_ch.last_sample)
                begin
                    want = close_block();
                    if (items_in < DIR_ROWS && DIR_TABLE[items_in].typed)
                        want = DIR_TABLE[items_in].want;
                    expected_rms_q.push_back(want);
                end
                items_in++;
            end
            if (cfg_ch.valid && cfg_ch.ready)
                mode_now = cfg_ch.weight_mode;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no handshake for %0d cycles, %0d results still pending",
                         idle_cycles, expected_rms_q.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver: random ready pattern, plus one long hold-off on request
    initial
    begin : receiver
        int span;
        int style;
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                span = $urandom_range(1, 40);
                style = $urandom_range(0, 3);
                repeat (span)
                begin
                    out_ch.ready <= (style == 0) ? 1'b0 :
                                    (style == 1) ? 1'($urandom_range(0, 1)) : 1'b1;
                    @(posedge clk);
                end
            end
        end
    end

    task automatic send_item(input logic [MAG_W-1:0] mag, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = 1;
                2: gap = $urandom_range(2, 6);
                default: gap = $urandom_range(7, 30);
            endcase
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.sample_magnitude <= mag;
        in_ch.last_sample <= last;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Hold input until every block has come out, then let the closing logic settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_rms_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_ch.valid <= 1'b1;
        cfg_ch.weight_mode <= mode;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_block(input int len, input mag_style_t style);
        logic [MAG_W-1:0] level;
        logic [MAG_W-1:0] mag;
        level = MAG_W'($urandom);
        for (int i = 0; i < len; i++)
        begin
            case (style)
                MAG_LOW:  mag = MAG_W'($urandom_range(0, 255));
                MAG_HIGH: mag = MAG_W'($urandom_range(65000, 65535));
                MAG_FLAT: mag = level;
                default:  mag = MAG_W'($urandom);
            endcase
            send_item(mag, i == len - 1);
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int phase_start;
        int len;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.sample_magnitude <= '0;
        in_ch.last_sample <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.weight_mode <= MODE_RING_MEAN;
        blk_energy = '0;
        blk_len = 0;
        foreach (rms_hist[i])
            rms_hist[i] = '0;
        hist_slot = 0;
        hist_sum = 0;
        rms_hi = '0;
        rms_lo = FLOOR_RESET;
        mode_now = MODE_RING_MEAN;
        items_in = 0;
        results_out = 0;
        errors = 0;
        idle_cycles = 0;
        random_items = 0;
        overlong_blocks = 0;
        burst_left = 0;
        hold_off_req = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_TABLE[i])
        begin
            if (DIR_TABLE[i].cfg != CFG_KEEP)
            begin
                wait_idle();
                write_mode(DIR_TABLE[i].cfg == CFG_BLOCK_RMS ? MODE_BLOCK_RMS : MODE_RING_MEAN);
            end
            send_item(DIR_TABLE[i].mag, DIR_TABLE[i].last);
        end

        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            wait_idle();
            write_mode(phase % 2 == 0 ? MODE_BLOCK_RMS : MODE_RING_MEAN);
            // stall the output while input keeps coming, so the block backs up
            if (phase == 1)
            begin
                hold_off_req = 1'b1;
                repeat (3)
                    send_block(2, MAG_ANY);
                random_items += 6;
            end
            // overlong block at full scale: drops the tail, widest sum
            if (phase == 2)
            begin
                send_block(MAX_BLOCK_DEF + 6, MAG_HIGH);
                random_items += MAX_BLOCK_DEF + 6;
                overlong_blocks++;
            end
            phase_start = random_items;
            while (random_items - phase_start < PHASE_ITEMS)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
                    6, 7, 8:          len = $urandom_range(5, 16);
                    default:          len = $urandom_range(17, 64);
                endcase
                send_block(len, mag_style_t'($urandom_range(0, 3)));
                random_items += len;
            end
            phase++;
        end

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_rms_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d sample items and %0d closed blocks over %0d random mode phases",
                 items_in, results_out, phase);
        $display("including %0d overlong full-scale block(s), one output hold-off, %0d mismatches",
                 overlong_blocks, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
